### hw/rtl/positional_array_list_assert.svh
// Assertion macros for the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PAL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/pal_pkg.sv
// Types and constants for the positional array list.
package pal_pkg;

  localparam int POS_W = 5;
  localparam int VAL_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    status_t                 status;
    logic [POS_W-1:0]        element_count;
  } rsp_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    upd;
    logic signed [VAL_W-1:0] value;
  } ctl_t;

endpackage

### hw/rtl/pal_cell.sv
// One storage cell of the list: holds a word, takes from a neighbor on a shift.
module pal_cell #(
  parameter int IDX = 0,
  parameter int PW  = 5
) (
  input  logic                            clk,
  input  pal_pkg::ctl_t                   ctl,
  input  logic [PW-1:0]                   pos,
  input  logic signed [pal_pkg::VAL_W-1:0] left,
  input  logic signed [pal_pkg::VAL_W-1:0] right,
  output logic signed [pal_pkg::VAL_W-1:0] data
);

  logic [PW-1:0]                    my_idx;
  logic                             here;
  logic                             above;
  logic signed [pal_pkg::VAL_W-1:0] data_next;

  assign my_idx = PW'(IDX);
  assign here   = (pos == my_idx);
  assign above  = (pos < my_idx);

  always_comb begin
    data_next = data;
    priority if ((ctl.ins || ctl.upd) && here) begin
      data_next = ctl.value;
    end else if (ctl.ins && above) begin
      data_next = left;
    end else if (ctl.del && (here || above)) begin
      data_next = right;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### hw/rtl/positional_array_list.sv
// Positional array list: insert, delete and update at an index over a row of cells.
// Latency: the response is valid in the cycle after the request transaction.
// Throughput: one transaction per cycle while responses are consumed; cells at and above the position shift.
// A stalled response holds, and a new request is taken as soon as it is consumed.
// Reset clears the element count and response valid; cell contents stay undefined.
`include "positional_array_list_assert.svh"

module positional_array_list #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pal_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pal_pkg::rsp_t rsp
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IDXW = $clog2(CAPACITY);
  localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic [CMPW-1:0]                  pos_c;
  logic [CMPW-1:0]                  cnt_c;
  logic                             full;
  logic                             empty;
  logic                             accept;
  logic                             ins_ok;
  logic                             del_ok;
  logic                             upd_ok;
  pal_pkg::status_t                 status;
  pal_pkg::ctl_t                    ctl;
  logic signed [pal_pkg::VAL_W-1:0] removed;
  logic signed [pal_pkg::VAL_W-1:0] ent [CAPACITY];
  logic                             rsp_valid_next;

  assign pos_c  = CMPW'(req.position);
  assign cnt_c  = CMPW'(count);
  assign full   = (cnt_c == CMPW'(CAPACITY));
  assign empty  = (count == '0);
  assign accept = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    upd_ok = 1'b0;
    status = pal_pkg::ST_RANGE;
    unique case (req.action)
      pal_pkg::ACT_INSERT: begin
        priority if (full) begin
          status = pal_pkg::ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          status = pal_pkg::ST_DONE;
          ins_ok = 1'b1;
        end
      end
      pal_pkg::ACT_DELETE, pal_pkg::ACT_UPDATE: begin
        priority if (empty) begin
          status = pal_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          status = pal_pkg::ST_DONE;
          del_ok = (req.action == pal_pkg::ACT_DELETE);
          upd_ok = (req.action == pal_pkg::ACT_UPDATE);
        end
      end
      default: begin
        status = pal_pkg::ST_RANGE;
      end
    endcase
  end

  assign ctl.ins   = accept && ins_ok;
  assign ctl.del   = accept && del_ok;
  assign ctl.upd   = accept && upd_ok;
  assign ctl.value = req.value;

  // Only read when the position is below the count, so the index is in range.
  assign removed = del_ok ? ent[pos_c[IDXW-1:0]] : '0;

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.del) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::VAL_W-1:0] left;
    logic signed [pal_pkg::VAL_W-1:0] right;

    // End cells feed back their own word; the first cell never selects it, the last keeps its word on a delete.
    if (i == 0) begin : g_first
      assign left = ent[i];
    end else begin : g_left
      assign left = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_right
      assign right = ent[i+1];
    end

    pal_cell #(
      .IDX (i),
      .PW  (CMPW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos_c),
      .left  (left),
      .right (right),
      .data  (ent[i])
    );
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (accept) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.removed_value <= removed;
      rsp.status        <= status;
      rsp.element_count <= pal_pkg::POS_W'(count_next);
    end
  end

  `PAL_ASSERT_IMP(a_count_cap, 1'b1, CMPW'(count) <= CMPW'(CAPACITY))
  `PAL_ASSERT_IMP(a_stall_means_busy, !req_ready, rsp_valid)
  `PAL_ASSERT_IMP(a_fail_no_word, rsp_valid && (rsp.status != pal_pkg::ST_DONE),
                  rsp.removed_value == '0)
  `PAL_ASSERT_NXT(a_insert_grows, ctl.ins, count == $past(count) + CW'(1))
  `PAL_ASSERT_NXT(a_reject_keeps, accept && (status != pal_pkg::ST_DONE),
                  count == $past(count))

endmodule

### sim/tb_top.sv
// Self-checking testbench for the positional array list: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP            = 16;
  localparam int RAND_PER_PHASE = 455;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  // Action code with no meaning; the block answers it with a range status.
  localparam logic [1:0] ACT_NONE = 2'd3;

  class list_scoreboard;
    logic signed [pal_pkg::VAL_W-1:0] words [CAP];
    int unsigned                      count;
    pal_pkg::rsp_t                    expected_rsp[$];
    int unsigned                      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(pal_pkg::req_t r);
      pal_pkg::rsp_t e;
      int            i;
      e               = '0;
      e.removed_value = '0;
      e.status        = pal_pkg::ST_DONE;
      case (r.action)
        pal_pkg::ACT_INSERT: begin
          if (count >= CAP) e.status = pal_pkg::ST_FULL;
          else if (r.position > count) e.status = pal_pkg::ST_RANGE;
          else begin
            for (i = count; i > r.position; i--) words[i] = words[i-1];
            words[r.position] = r.value;
            count++;
          end
        end
        pal_pkg::ACT_DELETE, pal_pkg::ACT_UPDATE: begin
          if (count == 0) e.status = pal_pkg::ST_EMPTY;
          else if (r.position >= count) e.status = pal_pkg::ST_RANGE;
          else if (r.action == pal_pkg::ACT_UPDATE) words[r.position] = r.value;
          else begin
            e.removed_value = words[r.position];
            for (i = r.position; i + 1 < count; i++) words[i] = words[i+1];
            count--;
          end
        end
        default: e.status = pal_pkg::ST_RANGE;
      endcase
      e.element_count = count[pal_pkg::POS_W-1:0];
      expected_rsp.push_back(e);
    endfunction

    function void check_response(pal_pkg::rsp_t a);
      pal_pkg::rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none pending: removed=%0d status=%0d count=%0d",
                 $time, a.removed_value, a.status, a.element_count);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.removed_value !== e.removed_value) begin
        $display("%0t: removed_value expected %0d actual %0d",
                 $time, e.removed_value, a.removed_value);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.element_count !== e.element_count) begin
        $display("%0t: element_count expected %0d actual %0d",
                 $time, e.element_count, a.element_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  pal_pkg::req_t  req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  pal_pkg::rsp_t  rsp;

  list_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  bit filling        = 1'b1;

  positional_array_list #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Response checking plus a watchdog on cycles with no transaction at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Entered just after a falling edge; returns just after a falling edge.
  task automatic issue(input logic [1:0] act, input int unsigned pos,
                       input logic [pal_pkg::VAL_W-1:0] val);
    pal_pkg::req_t r;
    r.action   = act;
    r.position = pos[pal_pkg::POS_W-1:0];
    r.value    = val;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  function automatic logic [pal_pkg::VAL_W-1:0] pick_word();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Drift between filling and draining so full and empty lists both come up often.
  task automatic issue_random();
    int unsigned roll;
    int unsigned pos;
    logic [1:0]  act;
    if (sb.count >= CAP) filling = 1'b0;
    else if (sb.count == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < 3) act = ACT_NONE;
    else if (roll < 20) act = pal_pkg::ACT_UPDATE;
    else if (roll < 35) act = filling ? pal_pkg::ACT_DELETE : pal_pkg::ACT_INSERT;
    else act = filling ? pal_pkg::ACT_INSERT : pal_pkg::ACT_DELETE;
    if ($urandom_range(9) == 0 || act == ACT_NONE) pos = $urandom_range(CAP, 0);
    else if (act == pal_pkg::ACT_INSERT) pos = $urandom_range(sb.count, 0);
    else if (sb.count == 0) pos = 0;
    else pos = $urandom_range(sb.count - 1, 0);
    issue(act, pos, pick_word());
  endtask

  initial begin
    int ph;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty-list cases, then inserts at front, back and middle, then updates and deletes.
    issue(pal_pkg::ACT_DELETE, 0, 32'h1234_5678);
    issue(pal_pkg::ACT_UPDATE, 0, 32'h1234_5678);
    issue(ACT_NONE, 0, 32'hDEAD_BEEF);
    issue(pal_pkg::ACT_INSERT, 1, 32'h0000_0001);
    issue(pal_pkg::ACT_INSERT, 16, 32'h0000_0002);
    issue(pal_pkg::ACT_INSERT, 0, 32'h7FFF_FFFF);
    issue(pal_pkg::ACT_INSERT, 1, 32'h8000_0000);
    issue(pal_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF);
    issue(pal_pkg::ACT_INSERT, 1, 32'h0000_0000);
    issue(pal_pkg::ACT_UPDATE, 2, 32'h5555_5555);
    issue(pal_pkg::ACT_UPDATE, 4, 32'hAAAA_AAAA);
    issue(pal_pkg::ACT_DELETE, 4, 32'h0);
    issue(pal_pkg::ACT_DELETE, 3, 32'h0);
    issue(pal_pkg::ACT_DELETE, 0, 32'h0);
    issue(ACT_NONE, 1, 32'h0);
    // Fill to capacity, then hit the full list and the top slot.
    while (sb.count < CAP) begin
      issue(pal_pkg::ACT_INSERT, $urandom_range(sb.count, 0), pick_word());
    end
    issue(pal_pkg::ACT_INSERT, 0, 32'h0BAD_F00D);
    issue(pal_pkg::ACT_INSERT, 16, 32'h0BAD_F00D);
    issue(pal_pkg::ACT_UPDATE, 15, 32'hAAAA_AAAA);
    issue(pal_pkg::ACT_DELETE, 16, 32'h0);
    issue(pal_pkg::ACT_DELETE, 15, 32'h0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) issue_random();
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
